### design/attempt_limiter_with_replay_ring_unit_macros.svh
// ----------------------------------------------------------------------------
// Attempt limiter assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ATTEMPT_LIMITER_WITH_REPLAY_RING_UNIT_MACROS_SVH
`define ATTEMPT_LIMITER_WITH_REPLAY_RING_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALRR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ALRR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

### design/alrr_pkg.sv
// ----------------------------------------------------------------------------
// Attempt limiter package
// Item types, status and opcode codes, and the ring command types.
// ----------------------------------------------------------------------------
package alrr_pkg;

	localparam int TIME_W   = 40;
	localparam int LOCK_W   = 41;
	localparam int CHAL_W   = 32;
	localparam int SEQ_W    = 32;
	localparam int CNT_W    = 4;
	localparam int WIN_W    = 16;
	localparam int CFG_W    = 16;
	localparam int NIBBLES  = CHAL_W / 4;

	localparam logic [1:0] OP_RESERVE = 2'd0;
	localparam logic [1:0] OP_RESET   = 2'd1;
	localparam logic [1:0] OP_REMOVE  = 2'd2;

	localparam logic CFG_WINDOW = 1'b0;
	localparam logic CFG_MAX    = 1'b1;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd300;
	localparam logic [CNT_W-1:0] MAX_RESET    = 4'd5;

	typedef enum logic [2:0] {
		ST_OK,
		ST_TIME_BACK,
		ST_BLOCKED,
		ST_LIMIT,
		ST_BAD_DIGITS,
		ST_COLLISION,
		ST_NO_RECORD,
		ST_SEQ_EXHAUSTED
	} status_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [TIME_W-1:0] now_seconds;
		logic [CHAL_W-1:0] candidate_challenge;
	} alrr_in_t;

	typedef struct packed {
		status_t           status;
		logic [CNT_W-1:0]  attempts_used;
		logic [LOCK_W-1:0] block_release;
		logic [SEQ_W-1:0]  record_sequence;
	} alrr_out_t;

	typedef struct packed {
		logic              search;
		logic              write;
		logic              clear;
		logic [CHAL_W-1:0] data;
	} ring_cmd_t;

	typedef struct packed {
		logic done;
		logic hit;
	} ring_sts_t;

endpackage

### design/alrr_ring.sv
// ----------------------------------------------------------------------------
// Recent challenge ring
// Holds the last issued challenges and searches them one entry per cycle.
// ----------------------------------------------------------------------------
module alrr_ring import alrr_pkg::*; #(
	parameter int RING_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ring_cmd_t cmd,
	output ring_sts_t sts
);

	localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W = $clog2(RING_DEPTH + 1);

	logic [CHAL_W-1:0] mem [RING_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  slot_q;
	logic [IDX_W-1:0]  idx_q;
	logic              active_q;
	logic              hit_q;
	logic              done_q;
	logic              rd_valid_s1;
	logic              last_s1;
	logic [CHAL_W-1:0] rd_data_s1;
	logic              at_last;
	logic              match;

	assign at_last = (FILL_W'(idx_q) == (fill_q - FILL_W'(1)));
	assign match   = (rd_data_s1 == cmd.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			slot_q      <= '0;
			idx_q       <= '0;
			active_q    <= 1'b0;
			hit_q       <= 1'b0;
			done_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
			last_s1     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.clear) begin
				fill_q <= '0;
				slot_q <= '0;
			end else if (cmd.write) begin
				if (fill_q != FILL_W'(RING_DEPTH)) begin
					fill_q <= fill_q + FILL_W'(1);
				end
				slot_q <= (slot_q == IDX_W'(RING_DEPTH - 1)) ? '0 : slot_q + IDX_W'(1);
			end

			rd_valid_s1 <= active_q;
			last_s1     <= active_q && at_last;

			if (cmd.search) begin
				hit_q <= 1'b0;
				idx_q <= '0;
				if (fill_q == '0) begin
					done_q <= 1'b1;
				end else begin
					active_q <= 1'b1;
				end
			end else begin
				if (active_q) begin
					idx_q <= idx_q + IDX_W'(1);
					if (at_last) begin
						active_q <= 1'b0;
					end
				end
				if (rd_valid_s1) begin
					hit_q <= hit_q | match;
					if (last_s1) begin
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// Single write port at the write slot, single registered read port for the scan.
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[slot_q] <= cmd.data;
		end
		if (active_q) begin
			rd_data_s1 <= mem[idx_q];
		end
	end

	assign sts.done = done_q;
	assign sts.hit  = hit_q;

endmodule

### design/attempt_limiter_with_replay_ring_unit.sv
// ----------------------------------------------------------------------------
// Attempt limiter with replay ring
// Fixed window attempt limiter with lockout and a ring of recent challenges.
// ----------------------------------------------------------------------------
// An item is accepted at a rising edge where start is high and busy is low.
// The cmd struct carries the opcode, the current time and, for a reserve, a
// candidate BCD challenge. Each item yields exactly one result: done is high
// for one cycle and the result struct carries the status together with the
// attempt count, the lockout release time and the record sequence as they
// stand after the item. The receiver cannot stall, so a result is shown once.
// For a reserve or a reset with a record, busy stays high from the cycle after
// acceptance until the cycle in which done rises; a new item may be accepted in
// that same cycle. Other items leave busy low. A remove, an ignored opcode or a
// reset with no record has done registered at the accepting edge; any other
// reset answers from S_TIME. A reserve refused before the ring search answers
// from S_TIME, S_LOCK or S_LIMIT. The ring is scanned through a single
// registered read port: a reserve that reaches the search waits in S_SEARCH
// until the ring reports done, then is refused on a hit or an exhausted
// sequence, or else commits in S_COMMIT.
// All time arithmetic goes through one shared 41-bit add and subtract unit,
// stepped by the sequencer, one comparison per cycle. Configuration writes
// (window_seconds at index 0, max_attempts at index 1) belong to idle periods.
// Asynchronous reset restores the default registers, drops the record and
// empties the ring logically; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "attempt_limiter_with_replay_ring_unit_macros.svh"

module attempt_limiter_with_replay_ring_unit import alrr_pkg::*; #(
	parameter int RING_DEPTH       = 16,
	parameter int CHALLENGE_DIGITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  alrr_in_t         cmd,
	output logic             done,
	output alrr_out_t        result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TIME,
		S_LOCK,
		S_WAGE,
		S_WEXP,
		S_LIMIT,
		S_SEARCH,
		S_COMMIT
	} state_t;

	state_t            state_q;

	// Configuration registers.
	logic [WIN_W-1:0]  window_q;
	logic [CNT_W-1:0]  max_q;

	// Record state.
	logic [TIME_W-1:0] ws_q;
	logic [TIME_W-1:0] last_q;
	logic [LOCK_W-1:0] lock_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SEQ_W-1:0]  seq_q;

	// Working copies for a reserve in flight.
	logic [TIME_W-1:0] ws_w_q;
	logic [LOCK_W-1:0] lock_w_q;
	logic [CNT_W-1:0]  cnt_w_q;
	logic [TIME_W-1:0] diff_q;

	// Latched item.
	logic [1:0]        op_q;
	logic [TIME_W-1:0] now_q;
	logic [CHAL_W-1:0] cand_q;

	logic              done_q;
	status_t           status_q;
	ring_cmd_t         ring_cmd_q;
	ring_sts_t         ring_sts;

	// Shared arithmetic unit.
	logic [LOCK_W-1:0] alu_a;
	logic [LOCK_W-1:0] alu_b;
	logic              alu_sub;
	logic [LOCK_W:0]   alu_sum;
	logic              alu_borrow;

	logic              bad_digits;
	logic [CNT_W-1:0]  cnt_next;

	alrr_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (ring_cmd_q),
		.sts   (ring_sts)
	);

	always_comb begin
		alu_a   = {1'b0, now_q};
		alu_b   = '0;
		alu_sub = 1'b1;
		unique case (state_q)
			S_TIME: alu_b = {1'b0, last_q};
			S_LOCK: alu_b = lock_q;
			S_WAGE: alu_b = {1'b0, ws_w_q};
			S_WEXP: begin
				alu_a = {1'b0, diff_q};
				alu_b = {{(LOCK_W - WIN_W){1'b0}}, window_q};
			end
			S_COMMIT: begin
				alu_b   = {{(LOCK_W - WIN_W){1'b0}}, window_q};
				alu_sub = 1'b0;
			end
			default: alu_sub = 1'b0;
		endcase
	end

	assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
		+ (LOCK_W + 1)'(alu_sub);
	assign alu_borrow = alu_sub & ~alu_sum[LOCK_W];

	// Digit check: nibbles inside the challenge length must be decimal, the
	// nibbles above it must be zero.
	always_comb begin
		bad_digits = 1'b0;
		for (int i = 0; i < NIBBLES; i++) begin
			if (i < CHALLENGE_DIGITS) begin
				if (cand_q[4*i +: 4] > 4'd9) begin
					bad_digits = 1'b1;
				end
			end else if (cand_q[4*i +: 4] != 4'd0) begin
				bad_digits = 1'b1;
			end
		end
	end

	assign cnt_next = cnt_w_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			window_q   <= WINDOW_RESET;
			max_q      <= MAX_RESET;
			ws_q       <= '0;
			last_q     <= '0;
			lock_q     <= '0;
			cnt_q      <= '0;
			seq_q      <= '0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			ring_cmd_q <= '0;
		end else begin
			done_q            <= 1'b0;
			ring_cmd_q.search <= 1'b0;
			ring_cmd_q.write  <= 1'b0;
			ring_cmd_q.clear  <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WINDOW: window_q <= cfg_data[WIN_W-1:0];
					CFG_MAX:    max_q    <= cfg_data[CNT_W-1:0];
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q   <= cmd.opcode;
						now_q  <= cmd.now_seconds;
						cand_q <= cmd.candidate_challenge;
						unique case (cmd.opcode)
							OP_RESERVE: state_q <= S_TIME;
							OP_RESET: begin
								if (seq_q == '0) begin
									status_q <= ST_NO_RECORD;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_TIME;
								end
							end
							OP_REMOVE: begin
								ws_q             <= '0;
								last_q           <= '0;
								lock_q           <= '0;
								cnt_q            <= '0;
								seq_q            <= '0;
								ring_cmd_q.clear <= 1'b1;
								status_q         <= ST_OK;
								done_q           <= 1'b1;
							end
							default: begin
								status_q <= ST_OK;
								done_q   <= 1'b1;
							end
						endcase
					end
				end
				S_TIME: begin
					ws_w_q   <= ws_q;
					lock_w_q <= lock_q;
					cnt_w_q  <= cnt_q;
					if (alu_borrow) begin
						status_q <= ST_TIME_BACK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (op_q == OP_RESET) begin
						if (seq_q == '1) begin
							status_q <= ST_SEQ_EXHAUSTED;
						end else begin
							cnt_q    <= '0;
							ws_q     <= '0;
							lock_q   <= '0;
							last_q   <= now_q;
							seq_q    <= seq_q + SEQ_W'(1);
							status_q <= ST_OK;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (lock_q != '0) begin
						state_q <= S_LOCK;
					end else if (cnt_q != '0) begin
						state_q <= S_WAGE;
					end else begin
						state_q <= S_LIMIT;
					end
				end
				S_LOCK: begin
					if (alu_borrow) begin
						status_q <= ST_BLOCKED;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						cnt_w_q  <= '0;
						ws_w_q   <= '0;
						lock_w_q <= '0;
						state_q  <= S_LIMIT;
					end
				end
				S_WAGE: begin
					diff_q  <= alu_sum[TIME_W-1:0];
					state_q <= alu_borrow ? S_LIMIT : S_WEXP;
				end
				S_WEXP: begin
					// The window has run out once its age reaches the window length.
					if (!alu_borrow) begin
						cnt_w_q <= '0;
						ws_w_q  <= '0;
					end
					state_q <= S_LIMIT;
				end
				S_LIMIT: begin
					if (cnt_w_q >= max_q) begin
						status_q <= ST_LIMIT;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (bad_digits) begin
						status_q <= ST_BAD_DIGITS;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						ring_cmd_q.search <= 1'b1;
						ring_cmd_q.data   <= cand_q;
						state_q           <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (ring_sts.done) begin
						if (ring_sts.hit) begin
							status_q <= ST_COLLISION;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else if (seq_q == '1) begin
							status_q <= ST_SEQ_EXHAUSTED;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_COMMIT;
						end
					end
				end
				S_COMMIT: begin
					// The adder forms now + window for a lockout armed here.
					ws_q   <= (cnt_w_q == '0) ? now_q : ws_w_q;
					cnt_q  <= cnt_next;
					lock_q <= (cnt_next == max_q) ? alu_sum[LOCK_W-1:0] : lock_w_q;
					last_q <= now_q;
					seq_q  <= seq_q + SEQ_W'(1);
					ring_cmd_q.write <= 1'b1;
					ring_cmd_q.data  <= cand_q;
					status_q <= ST_OK;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy                   = (state_q != S_IDLE);
	assign done                   = done_q;
	assign result.status          = status_q;
	assign result.attempts_used   = cnt_q;
	assign result.block_release   = lock_q;
	assign result.record_sequence = seq_q;

	// A result is only reported once the sequencer is back at rest.
	`ALRR_ASSERT_SAME(a_done_idle, done, !busy)
	// An accepted reserve, or a reset with a record, leaves the block busy and with no result in the following cycle.
	`ALRR_ASSERT_NEXT(a_start_busy, start && !busy && (cmd.opcode == OP_RESERVE || (cmd.opcode == OP_RESET && seq_q != '0)), busy && !done)
	// The record sequence only steps by one or drops to zero.
	`ALRR_ASSERT_NEXT(a_seq_step, 1'b1, seq_q == $past(seq_q) || seq_q == $past(seq_q) + SEQ_W'(1) || seq_q == '0)

endmodule
